### src/fixed_block_free_list_allocator_core_defines.svh
// assertion macros used by the bound checker file
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define FBFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbfl assertion failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbfl assertion failed");

`endif

### src/fbfl_pkg.sv
package fbfl_pkg;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 10;
	localparam int LINK_W     = 11;
	localparam int CNT_W      = 11;
	localparam int SIZE_W     = 16;
	localparam int BYTE_W     = 26;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OFF_W      = IDX_W + SIZE_W;
	localparam int USED_W     = CNT_W + SIZE_W;

	localparam int MAX_BLOCKS = 1024;
	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd8;
	localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 11'd1024;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 2'd0,
		FN_FREE    = 2'd1,
		FN_INIT    = 2'd2,
		FN_DESTROY = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK            = 3'd0,
		STAT_NOT_SETUP     = 3'd1,
		STAT_ALREADY_SETUP = 3'd2,
		STAT_BAD_SIZE      = 3'd3,
		STAT_EMPTY         = 3'd4,
		STAT_BAD_INDEX     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   gidx;
		logic [CNT_W-1:0]   free;
		logic               ready;
		logic [CNT_W-1:0]   cnt;
		logic [SIZE_W-1:0]  size;
	} res_t;

endpackage

### src/fixed_block_free_list_allocator_core.sv
// fixed-size block pool allocator with the free list kept as a chain of next links in one
// 1024 x 11 synchronous ram (one write port, one registered read port that always reads
// the entry at the list head). free, destroy and every rejected request complete on the
// cycle they are accepted, so one of them can be taken every cycle while the result stage
// can take it; a successful allocate waits in a read state, as the head's next link comes
// out of the ram's registered read port after the head is known; a successful init writes
// one link per cycle in a walk state, and no request is taken until it ends. the ram needs
// no clearing after reset since every link is written before it is read. a result passes
// a result stage and a registered output stage (products for byte_offset and bytes_used
// sit between them), so one more request can be taken while the last result waits at the
// output. configuration is accepted only while no allocate or init is under way
module fixed_block_free_list_allocator_core #(
	parameter int unsigned MIN_BLOCK_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fbfl_pkg::FUNC_W-1:0]         func,
	input  logic [fbfl_pkg::IDX_W-1:0]          block_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fbfl_pkg::STATUS_W-1:0]       status,
	output logic [fbfl_pkg::IDX_W-1:0]          granted_index,
	output logic [fbfl_pkg::BYTE_W-1:0]         byte_offset,
	output logic [fbfl_pkg::CNT_W-1:0]          free_count,
	output logic [fbfl_pkg::BYTE_W-1:0]         bytes_used,
	output logic                                ready_res
);
	import fbfl_pkg::*;

	// configuration registers
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]  block_count_q;

	// pool state
	state_t            state_q, state_d;
	logic [LINK_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  free_q, free_d;
	logic              ready_q, ready_d;
	logic [SIZE_W-1:0] lat_size_q, lat_size_d;
	logic [CNT_W-1:0]  lat_count_q, lat_count_d;
	logic [IDX_W-1:0]  walk_q, walk_d;

	// link memory
	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
	logic [LINK_W-1:0] rdata_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [LINK_W-1:0] mem_wdata;

	// result stage and output stage
	logic              res_valid_s1;
	res_t              res_s1;
	res_t              res_d;
	logic              emit;
	status_t           emit_status;
	logic [IDX_W-1:0]  emit_gidx;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [IDX_W-1:0]  out_gidx_q;
	logic [BYTE_W-1:0] out_off_q;
	logic [CNT_W-1:0]  out_free_q;
	logic [BYTE_W-1:0] out_used_q;
	logic              out_ready_q;

	logic              in_acc;
	logic              out_free;
	logic              s1_free;
	func_t             fn;
	logic              head_ok;
	logic              idx_ok;
	logic              init_ok;
	logic              walk_last;
	logic [CNT_W-1:0]  free_inc;
	logic [CNT_W-1:0]  free_dec;
	logic [OFF_W-1:0]  off_full;
	logic [USED_W-1:0] used_full;

	// handshakes: the output register frees when it is empty or being taken
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_free   = !res_valid_s1 || out_free;
	assign in_stall  = !((state_q == ST_IDLE) && s1_free);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);

	assign fn = func_t'(func);

	// checks on the request against the current pool
	assign head_ok   = (head_q < lat_count_q) && (head_q < END_MARK);
	assign idx_ok    = ({1'b0, block_index} < lat_count_q);
	assign init_ok   = (block_size_q >= SIZE_W'(MIN_BLOCK_BYTES)) && (block_count_q != '0)
		&& (block_count_q <= CNT_W'(MAX_BLOCKS));
	assign walk_last = ({1'b0, walk_q} == (lat_count_q - CNT_W'(1)));

	// free counter saturates both ways
	assign free_inc = (free_q == '1) ? free_q : free_q + CNT_W'(1);
	assign free_dec = (free_q == '0) ? free_q : free_q - CNT_W'(1);

	// operation control
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		free_d      = free_q;
		ready_d     = ready_q;
		lat_size_d  = lat_size_q;
		lat_count_d = lat_count_q;
		walk_d      = walk_q;
		mem_we      = 1'b0;
		mem_waddr   = block_index;
		mem_wdata   = head_q;
		emit        = 1'b0;
		emit_status = STAT_OK;
		emit_gidx   = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (fn)
						FN_ALLOC: begin
							if (!ready_q) begin
								emit        = 1'b1;
								emit_status = STAT_NOT_SETUP;
							end else if (!head_ok) begin
								emit        = 1'b1;
								emit_status = STAT_EMPTY;
							end else begin
								// wait for the head's next link from the ram
								state_d = ST_READ;
							end
						end
						FN_FREE: begin
							if (!ready_q) begin
								emit        = 1'b1;
								emit_status = STAT_NOT_SETUP;
							end else if (!idx_ok) begin
								emit        = 1'b1;
								emit_status = STAT_BAD_INDEX;
							end else begin
								// push: link the block in front of the old head
								mem_we    = 1'b1;
								mem_waddr = block_index;
								mem_wdata = head_q;
								head_d    = {1'b0, block_index};
								free_d    = free_inc;
								emit      = 1'b1;
							end
						end
						FN_INIT: begin
							if (ready_q) begin
								emit        = 1'b1;
								emit_status = STAT_ALREADY_SETUP;
							end else if (!init_ok) begin
								emit        = 1'b1;
								emit_status = STAT_BAD_SIZE;
							end else begin
								lat_size_d  = block_size_q;
								lat_count_d = block_count_q;
								walk_d      = '0;
								state_d     = ST_WALK;
							end
						end
						FN_DESTROY: begin
							if (!ready_q) begin
								emit        = 1'b1;
								emit_status = STAT_NOT_SETUP;
							end else begin
								head_d      = END_MARK;
								free_d      = '0;
								lat_size_d  = '0;
								lat_count_d = '0;
								ready_d     = 1'b0;
								emit        = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				// pop: the registered read holds the head's link; hold here while the
				// result stage is full, the read repeats at the same address
				if (s1_free) begin
					head_d    = rdata_q;
					free_d    = free_dec;
					emit      = 1'b1;
					emit_gidx = head_q[IDX_W-1:0];
					state_d   = ST_IDLE;
				end
			end
			ST_WALK: begin
				// chain block i to block i+1, the last one to the end marker
				mem_we    = 1'b1;
				mem_waddr = walk_q;
				mem_wdata = walk_last ? END_MARK : LINK_W'(walk_q) + LINK_W'(1);
				if (walk_last) begin
					if (s1_free) begin
						head_d  = '0;
						free_d  = lat_count_q;
						ready_d = 1'b1;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					walk_d = walk_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result reflects the pool after the operation
	always_comb begin
		res_d.status = emit_status;
		res_d.gidx   = emit_gidx;
		res_d.free   = free_d;
		res_d.ready  = ready_d;
		res_d.cnt    = lat_count_d;
		res_d.size   = lat_size_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= BLOCK_SIZE_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLOCK_SIZE:  block_size_q  <= cfg_data;
				REG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pool control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= END_MARK;
			free_q       <= '0;
			ready_q      <= 1'b0;
			lat_size_q   <= '0;
			lat_count_q  <= '0;
			walk_q       <= '0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			free_q      <= free_d;
			ready_q     <= ready_d;
			lat_size_q  <= lat_size_d;
			lat_count_q <= lat_count_d;
			walk_q      <= walk_d;
			if (emit) begin
				res_valid_s1 <= 1'b1;
			end else if (out_free) begin
				res_valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= res_valid_s1;
			end
		end
	end

	// link ram: one write port, read port always follows the head
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= link_mem[head_q[IDX_W-1:0]];
	end

	// products for the output stage
	assign off_full  = OFF_W'(res_s1.gidx) * OFF_W'(res_s1.size);
	assign used_full = (res_s1.cnt > res_s1.free)
		? USED_W'(res_s1.cnt - res_s1.free) * USED_W'(res_s1.size) : '0;

	// result and output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_s1 <= res_d;
		end
		if (res_valid_s1 && out_free) begin
			out_status_q <= res_s1.status;
			out_gidx_q   <= res_s1.gidx;
			out_off_q    <= off_full[BYTE_W-1:0];
			out_free_q   <= res_s1.free;
			out_used_q   <= used_full[BYTE_W-1:0];
			out_ready_q  <= res_s1.ready;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_index = out_gidx_q;
	assign byte_offset   = out_off_q;
	assign free_count    = out_free_q;
	assign bytes_used    = out_used_q;
	assign ready_res     = out_ready_q;

endmodule

### src/fbfl_checker.sv
`include "fixed_block_free_list_allocator_core_defines.svh"

module fbfl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [fbfl_pkg::STATUS_W-1:0]   status,
	input logic [fbfl_pkg::IDX_W-1:0]      granted_index,
	input logic [fbfl_pkg::BYTE_W-1:0]     byte_offset,
	input logic [fbfl_pkg::CNT_W-1:0]      free_count,
	input logic [fbfl_pkg::BYTE_W-1:0]     bytes_used,
	input logic                            ready_res
);
	import fbfl_pkg::*;

	// a stalled result stays offered
	`FBFL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// only a successful allocate reports a block
	`FBFL_ASSERT_NOW(a_grant_ok, clk, arst_n, out_valid && (status != STAT_OK),
		(granted_index == '0) && (byte_offset == '0))

	// a pool that is not set up has nothing free and nothing in use
	`FBFL_ASSERT_NOW(a_idle_pool, clk, arst_n, out_valid && !ready_res,
		(free_count == '0) && (bytes_used == '0))

	// status code stays within the defined set
	`FBFL_ASSERT_NOW(a_status_code, clk, arst_n, out_valid,
		(status == STAT_OK) || (status == STAT_NOT_SETUP) || (status == STAT_ALREADY_SETUP)
		|| (status == STAT_BAD_SIZE) || (status == STAT_EMPTY) || (status == STAT_BAD_INDEX))

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (.*);

### test/fbfl_pool_checker.sv
module fbfl_pool_checker #(
	parameter int unsigned MIN_BLOCK_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [fbfl_pkg::FUNC_W-1:0]     func,
	input  logic [fbfl_pkg::IDX_W-1:0]      block_index,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [fbfl_pkg::STATUS_W-1:0]   status,
	input  logic [fbfl_pkg::IDX_W-1:0]      granted_index,
	input  logic [fbfl_pkg::BYTE_W-1:0]     byte_offset,
	input  logic [fbfl_pkg::CNT_W-1:0]      free_count,
	input  logic [fbfl_pkg::BYTE_W-1:0]     bytes_used,
	input  logic                            ready_res,
	output int unsigned                     failures,
	output int unsigned                     replies_waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import fbfl_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  gidx;
		logic [BYTE_W-1:0] offset;
		logic [CNT_W-1:0]  free;
		logic [BYTE_W-1:0] used;
		logic              up;
	} pool_reply_t;

	// pool image
	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
	logic [LINK_W-1:0] head_blk;
	logic [CNT_W-1:0]  free_blks;
	logic              pool_up;
	logic [SIZE_W-1:0] lat_size;
	logic [CNT_W-1:0]  lat_cnt;
	logic [SIZE_W-1:0] cfg_size;
	logic [CNT_W-1:0]  cfg_cnt;

	pool_reply_t replies_due [$];

	function automatic pool_reply_t step_pool(input func_t op, input logic [IDX_W-1:0] bi);
		pool_reply_t       r;
		logic [LINK_W-1:0] g;
		logic [26:0]       prod;
		int                k;
		r = '0;
		r.status = STAT_OK;
		case (op)
			FN_ALLOC: begin
				if (!pool_up)
					r.status = STAT_NOT_SETUP;
				else if (head_blk >= lat_cnt || head_blk >= END_MARK)
					r.status = STAT_EMPTY;
				else begin
					g = head_blk;
					head_blk = link_mem[g[IDX_W-1:0]];
					if (free_blks != '0)
						free_blks = free_blks - 1'b1;
					r.gidx = g[IDX_W-1:0];
					r.offset = BYTE_W'(g) * BYTE_W'(lat_size);
				end
			end
			FN_FREE: begin
				if (!pool_up)
					r.status = STAT_NOT_SETUP;
				else if (bi >= lat_cnt)
					r.status = STAT_BAD_INDEX;
				else begin
					link_mem[bi] = head_blk;
					head_blk = LINK_W'(bi);
					// counter sticks at its top value
					if (free_blks != '1)
						free_blks = free_blks + 1'b1;
				end
			end
			FN_INIT: begin
				if (pool_up)
					r.status = STAT_ALREADY_SETUP;
				else if (cfg_size < MIN_BLOCK_BYTES || cfg_cnt == '0 || cfg_cnt > MAX_BLOCKS)
					r.status = STAT_BAD_SIZE;
				else begin
					for (k = 0; k < cfg_cnt; k++)
						link_mem[k] = (k + 1 == cfg_cnt) ? END_MARK : LINK_W'(k + 1);
					lat_size = cfg_size;
					lat_cnt = cfg_cnt;
					head_blk = '0;
					free_blks = cfg_cnt;
					pool_up = 1'b1;
				end
			end
			default: begin
				if (!pool_up)
					r.status = STAT_NOT_SETUP;
				else begin
					head_blk = END_MARK;
					free_blks = '0;
					lat_size = '0;
					lat_cnt = '0;
					pool_up = 1'b0;
				end
			end
		endcase
		r.free = free_blks;
		if (lat_cnt > free_blks) begin
			prod = (lat_cnt - free_blks) * lat_size;
			r.used = prod[BYTE_W-1:0];
		end
		r.up = pool_up;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		pool_reply_t got;
		pool_reply_t want;
		if (!arst_n) begin
			cfg_size = BLOCK_SIZE_RST;
			cfg_cnt = BLOCK_COUNT_RST;
			head_blk = END_MARK;
			free_blks = '0;
			pool_up = 1'b0;
			lat_size = '0;
			lat_cnt = '0;
			failures = 0;
			replies_due.delete();
			replies_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BLOCK_SIZE)
					cfg_size = cfg_data[SIZE_W-1:0];
				else if (cfg_index == REG_BLOCK_COUNT)
					cfg_cnt = cfg_data[CNT_W-1:0];
			end
			if (out_valid && !out_stall) begin
				got = '{status_t'(status), granted_index, byte_offset, free_count, bytes_used,
					ready_res};
				if (replies_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result with no request pending: status %0d index %0d",
							$time, got.status, got.gidx);
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("%0t: mismatch (exp/got) status %0d/%0d index %0d/%0d ",
								$time, want.status, got.status, want.gidx, got.gidx,
								"offset %0d/%0d free %0d/%0d used %0d/%0d ready %0b/%0b",
								want.offset, got.offset, want.free, got.free,
								want.used, got.used, want.up, got.up);
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(step_pool(func_t'(func), block_index));
			replies_waiting <= replies_due.size();
		end
	end

endmodule

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbfl_pkg::*;

	localparam int ITEMS_TARGET   = 1900;
	localparam int HOLD_CYCLES    = 400;   // receiver hold-off for the back-pressure check
	localparam int WATCHDOG_LIMIT = 8000;  // a full-size init alone walks every block before it answers
	localparam int SETTLE_CYCLES  = 20;
	localparam int FILL_FREES     = 1100;  // enough pushes to pin the free counter at its top

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	func_t                 func;
	logic [IDX_W-1:0]      block_index;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_stall;
	logic [STATUS_W-1:0]   status;
	logic [IDX_W-1:0]      granted_index;
	logic [BYTE_W-1:0]     byte_offset;
	logic [CNT_W-1:0]      free_count;
	logic [BYTE_W-1:0]     bytes_used;
	logic                  ready_res;

	int unsigned failures;
	int unsigned replies_waiting;
	int unsigned requests_sent = 0;
	int unsigned quiet_cycles;

	// block count last written, so request indexes can follow the pool size
	logic [CNT_W-1:0]  cnt_now  = BLOCK_COUNT_RST;

	// idling controls for the sender and the receiver
	bit tx_calm  = 1'b0;
	bit rx_calm  = 1'b0;
	bit hold_req = 1'b0;

	always #2ns clk = ~clk;

	fixed_block_free_list_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.block_index   (block_index),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.granted_index (granted_index),
		.byte_offset   (byte_offset),
		.free_count    (free_count),
		.bytes_used    (bytes_used),
		.ready_res     (ready_res)
	);

	// shadow of the pool, compares every result in order
	fbfl_pool_checker pool_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.block_index     (block_index),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_index   (granted_index),
		.byte_offset     (byte_offset),
		.free_count      (free_count),
		.bytes_used      (bytes_used),
		.ready_res       (ready_res),
		.failures        (failures),
		.replies_waiting (replies_waiting)
	);

	// gap lengths: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// block to free: mostly inside the configured pool, sometimes anywhere
	function automatic logic [IDX_W-1:0] pick_index();
		if (cnt_now != '0 && cnt_now <= MAX_BLOCKS && $urandom_range(0, 99) < 85)
			return IDX_W'($urandom_range(0, cnt_now - 1));
		return IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
	endfunction

	// one request, held until the block takes it; valid stays up for a follow-on request
	task automatic send_req(input func_t op, input logic [IDX_W-1:0] bi);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= op;
		block_index <= bi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_waiting != 0) @(posedge clk);
	endtask

	// one register write; valid is left high so writes can run back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic configure(input bit wr_size, input logic [SIZE_W-1:0] sz,
		input bit wr_cnt, input logic [CNT_W-1:0] cn);
		if (wr_size) begin
			write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(sz));
		end
		if (wr_cnt) begin
			write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(cn));
			cnt_now = cn;
		end
		cfg_valid <= 1'b0;
	endtask

	// one pool lifetime: settings, init, a random mix of allocate and free, destroy
	task automatic run_pool_phase(input bit squeeze);
		int               n_ops;
		int               r;
		int               i;
		logic [SIZE_W-1:0] sz;
		logic [CNT_W-1:0]  cn;
		r = $urandom_range(0, 99);
		if (r < 70)
			sz = SIZE_W'($urandom_range(8, 64));
		else if (r < 85)
			sz = SIZE_W'($urandom_range(0, 65535));
		else if (r < 93)
			sz = '1;
		else
			sz = SIZE_W'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 75)
			cn = CNT_W'($urandom_range(1, 24));
		else if (r < 87)
			cn = CNT_W'($urandom_range(25, 200));
		else if (r < 92)
			cn = CNT_W'(MAX_BLOCKS);
		else if (r < 96)
			cn = '0;
		else
			cn = CNT_W'($urandom_range(MAX_BLOCKS + 1, 2047));
		if (squeeze) begin
			// small legal pool so the hold-off stays short of a long init
			sz = SIZE_W'($urandom_range(8, 64));
			cn = CNT_W'($urandom_range(4, 16));
		end
		configure(squeeze || $urandom_range(0, 9) < 7, sz, squeeze || $urandom_range(0, 9) < 7, cn);

		tx_calm = squeeze || $urandom_range(0, 3) == 0;
		rx_calm = !squeeze && $urandom_range(0, 3) == 0;
		// receiver holds off while requests keep coming, so the block backs up
		if (squeeze)
			hold_req = 1'b1;

		n_ops = $urandom_range(30, 70);
		send_req(FN_INIT, IDX_W'($urandom));
		for (i = 0; i < n_ops; i++) begin
			// sender pauses mid-lifetime until the results have caught up
			if (i == n_ops / 2 && (squeeze || $urandom_range(0, 3) == 0))
				drain();
			r = $urandom_range(0, 99);
			if (r < 45)
				send_req(FN_ALLOC, IDX_W'($urandom));
			else if (r < 85)
				send_req(FN_FREE, pick_index());
			else if (r < 89)
				send_req(FN_INIT, IDX_W'($urandom));
			else if (r < 93) begin
				send_req(FN_DESTROY, IDX_W'($urandom));
				if ($urandom_range(0, 1) == 1)
					send_req(FN_INIT, IDX_W'($urandom));
			end else
				send_req(func_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1023)));
		end
		send_req(FN_DESTROY, IDX_W'($urandom));
		drain();
	endtask

	// full pool flooded with frees, double frees included, till the free counter saturates
	task automatic run_fill_phase();
		int i;
		configure(1'b1, SIZE_W'($urandom_range(8, 65535)), 1'b1, CNT_W'(MAX_BLOCKS));
		tx_calm = $urandom_range(0, 1) == 1;
		rx_calm = $urandom_range(0, 1) == 1;
		send_req(FN_INIT, '0);
		for (i = 0; i < FILL_FREES; i++) begin
			if ($urandom_range(0, 99) < 98)
				send_req(FN_FREE, IDX_W'($urandom_range(0, MAX_BLOCKS - 1)));
			else
				send_req(FN_ALLOC, IDX_W'($urandom));
		end
		send_req(FN_DESTROY, '0);
		drain();
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!rx_calm) begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// watchdog: too long without any handshake on any channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1)
			quiet_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("fixed_block_free_list_allocator_core test failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		int phase_no;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FN_ALLOC;
		block_index <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_BLOCK_SIZE;
		cfg_data    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refused before any init
		send_req(FN_ALLOC, '0);
		send_req(FN_FREE, '1);
		drain();

		// block size one below the minimum
		configure(1'b1, 16'd7, 1'b1, 11'd4);
		send_req(FN_INIT, '0);
		drain();

		// largest block size but no blocks
		configure(1'b1, '1, 1'b1, '0);
		send_req(FN_INIT, '0);
		drain();

		// count beyond pool capacity, every count bit set
		configure(1'b0, '0, 1'b1, '1);
		send_req(FN_INIT, '0);
		drain();

		// four of the largest blocks: init twice, exhaust, bad and double frees
		configure(1'b0, '0, 1'b1, 11'd4);
		send_req(FN_INIT, '0);
		send_req(FN_INIT, '0);
		repeat (4) send_req(FN_ALLOC, '0);
		send_req(FN_ALLOC, '0);          // empty pool
		send_req(FN_FREE, '1);           // index far out of range
		send_req(FN_FREE, 10'd4);        // first index past the pool
		send_req(FN_FREE, '0);
		send_req(FN_FREE, '0);           // double free links the block to itself
		repeat (3) send_req(FN_ALLOC, '0); // free counter runs down and sticks at zero
		send_req(FN_DESTROY, '0);
		send_req(FN_DESTROY, '0);        // already torn down
		drain();

		// full-size pool at the minimum block size; a push beyond the pool size zeroes usage
		configure(1'b1, 16'd8, 1'b1, CNT_W'(MAX_BLOCKS));
		send_req(FN_INIT, '0);
		send_req(FN_FREE, '1);
		send_req(FN_ALLOC, '0);
		send_req(FN_DESTROY, '0);
		drain();

		// random pool lifetimes, the first one under back-pressure, one flood of frees
		phase_no = 0;
		while (requests_sent < ITEMS_TARGET) begin
			if (phase_no == 3)
				run_fill_phase();
			else
				run_pool_phase(phase_no == 0);
			phase_no++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && replies_waiting == 0)
			$display("fixed_block_free_list_allocator_core test passed");
		else
			$display("fixed_block_free_list_allocator_core test failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/fbfl_pkg.sv
src/fixed_block_free_list_allocator_core.sv
src/fbfl_checker.sv
test/fbfl_pool_checker.sv
test/tb.sv
